### src/fph_pkg.sv
package fph_pkg;

    localparam int unsigned HASH_W = 64;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned BYTE_W = 8;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // FNV-1a 64-bit offset basis.
    localparam hash_t HASH_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;

    // The prime 0x100000001B3 is 2^40 plus a 9-bit constant. A multiply by it
    // is therefore a shift by 40 plus a narrow product.
    localparam int unsigned PRIME_SHIFT = 40;
    localparam hash_t       PRIME_LOW   = 64'h0000_0000_0000_01B3;

    // Configuration register indexes.
    localparam logic CFG_STAGE_CODE = 1'b0;
    localparam logic CFG_SLOT_BASE  = 1'b1;

endpackage

### src/fph_in_if.sv
interface fph_in_if;

    logic          valid;
    logic          ready;
    fph_pkg::word_t data_word;
    logic          has_word;
    logic          last_word;

    modport source (output valid, output data_word, output has_word, output last_word,
                    input ready);
    modport sink   (input valid, input data_word, input has_word, input last_word,
                    output ready);

endinterface

### src/fph_out_if.sv
interface fph_out_if;

    logic          valid;
    logic          ready;
    fph_pkg::hash_t hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);

endinterface

### src/fnv1a64_program_hash_core.sv
// FNV-1a 64-bit hash over a program identity. Each program is a run of input
// transactions closed by one with last_word set. On the first transaction of a
// program the hash starts at the offset basis and folds the stage code byte and
// the four slot base bytes (least significant first); stage_code and slot_base
// are sampled at that moment, so writes during a program apply to the next one.
// Every transaction with has_word set then folds the four bytes of data_word,
// least significant first. The closing transaction produces one output
// transaction carrying the final hash. All folds run through a single shared
// fold unit (one 64-bit by 9-bit product plus one 64-bit add) at one byte per
// cycle, and the input is not ready while a transaction is being worked on.
// After a transaction is accepted, ready stays low while its bytes are folded
// and through the closing step. The final hash sits in an output register,
// so a new program can be accepted while the previous result waits; the
// closing step of the next program holds until that register is free.
module fnv1a64_program_hash_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  fph_pkg::word_t    cfg_wdata,
    fph_in_if.sink            in_ch,
    fph_out_if.source         out_ch
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FOLD   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam int unsigned SEQ_BYTES = 9;
    localparam int unsigned SEQ_W     = SEQ_BYTES * fph_pkg::BYTE_W;
    localparam int unsigned CNT_W     = $clog2(SEQ_BYTES + 1);

    // Configuration registers.
    fph_pkg::byte_t stage_code_reg;
    fph_pkg::word_t slot_base_reg;

    // Sequencer state.
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_program_reg, in_program_next;
    logic             last_pending_reg, last_pending_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath.
    fph_pkg::hash_t   hash_reg, hash_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    fph_pkg::hash_t   out_hash_reg, out_hash_next;

    fph_pkg::hash_t   fold_x;
    fph_pkg::hash_t   fold_result;
    logic             in_accept;
    logic             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_code_reg <= '0;
            slot_base_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fph_pkg::CFG_STAGE_CODE: stage_code_reg <= cfg_wdata[fph_pkg::BYTE_W-1:0];
                fph_pkg::CFG_SLOT_BASE:  slot_base_reg  <= cfg_wdata;
                default:                 stage_code_reg <= stage_code_reg;
            endcase
        end
    end

    // The shared fold unit: hash = (hash ^ byte) * prime, modulo 2^64.
    always_comb
    begin
        fold_x      = hash_reg ^ {{(fph_pkg::HASH_W-fph_pkg::BYTE_W){1'b0}},
                                  seq_reg[fph_pkg::BYTE_W-1:0]};
        fold_result = (fold_x << fph_pkg::PRIME_SHIFT) + (fold_x * fph_pkg::PRIME_LOW);
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign in_accept         = in_ch.valid && in_ch.ready;
    assign out_free          = !out_valid_reg || out_ch.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.hash_value = out_hash_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        in_program_next   = in_program_reg;
        last_pending_next = last_pending_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        hash_next         = hash_reg;
        seq_next          = seq_reg;
        out_hash_next     = out_hash_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    last_pending_next = in_ch.last_word;
                    in_program_next   = 1'b1;
                    if (!in_program_reg)
                    begin
                        // Open a program: stage byte and slot bytes go first.
                        hash_next = fph_pkg::HASH_OFFSET_BASIS;
                        seq_next  = {in_ch.data_word, slot_base_reg, stage_code_reg};
                        cnt_next  = in_ch.has_word ? CNT_W'(9) : CNT_W'(5);
                        state_next = ST_FOLD;
                    end
                    else
                    begin
                        seq_next = {{(SEQ_W-fph_pkg::WORD_W){1'b0}}, in_ch.data_word};
                        if (in_ch.has_word)
                        begin
                            cnt_next   = CNT_W'(4);
                            state_next = ST_FOLD;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_FOLD:
            begin
                hash_next = fold_result;
                seq_next  = {{fph_pkg::BYTE_W{1'b0}}, seq_reg[SEQ_W-1:fph_pkg::BYTE_W]};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_pending_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_hash_next   = hash_reg;
                    in_program_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            in_program_reg   <= 1'b0;
            last_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            in_program_reg   <= in_program_next;
            last_pending_reg <= last_pending_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        seq_reg      <= seq_next;
        out_hash_reg <= out_hash_next;
    end

    // A new result appears only out of the closing step of a program.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside the closing step");

    // The byte counter is empty whenever the sequencer is idle.
    a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> cnt_reg == '0)
        else $error("byte counter not empty while idle");

    // The first transaction of a program always folds the prefix bytes.
    a_open_folds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !in_program_reg) |=> state_reg == ST_FOLD && cnt_reg >= CNT_W'(5))
        else $error("program opened without folding stage and slot");

    // A closing step with a blocked output register waits and keeps its hash.
    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && last_pending_reg && out_valid_reg && !out_ch.ready)
        |=> state_reg == ST_FINISH && $stable(hash_reg))
        else $error("closing step left while output register was full");

endmodule

### dv/fph_hash_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both channels, keeps a running FNV-1a 64
// model of the program hash, and compares each output transaction against the
// oldest expected hash.
module fph_hash_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  fph_pkg::word_t cfg_wdata,
    fph_in_if              in_ch,
    fph_out_if             out_ch,
    output int unsigned    mismatch_count,
    output int unsigned    pending_hashes
);

    localparam fph_pkg::hash_t FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam fph_pkg::hash_t FNV_PRIME = 64'h0000_0100_0000_01B3;

    fph_pkg::byte_t stage_shadow;
    fph_pkg::word_t slot_shadow;
    fph_pkg::hash_t hash_acc;
    logic           prog_open;
    int unsigned    errors;
    fph_pkg::hash_t expected_hashes[$];

    function automatic fph_pkg::hash_t fnv_fold_byte(fph_pkg::hash_t h, fph_pkg::byte_t b);
        return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    function automatic fph_pkg::hash_t fnv_fold_word(fph_pkg::hash_t h, fph_pkg::word_t w);
        fph_pkg::hash_t acc;
        acc = h;
        for (int k = 0; k < 4; k++)
        begin
            acc = fnv_fold_byte(acc, w[8*k +: 8]);
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fph_pkg::hash_t got;
        fph_pkg::hash_t want;
        if (!rst_n)
        begin
            stage_shadow = '0;
            slot_shadow  = '0;
            hash_acc     = '0;
            prog_open    = 1'b0;
            errors       = 0;
            expected_hashes.delete();
            mismatch_count <= 0;
            pending_hashes <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.hash_value;
                if (expected_hashes.size() == 0)
                begin
                    $error("hash_value %h arrived with no hash expected", got);
                    errors++;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (got !== want)
                    begin
                        $error("hash_value mismatch: expected %h, actual %h", want, got);
                        errors++;
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
            begin
                if (!prog_open)
                begin
                    hash_acc  = fnv_fold_word(fnv_fold_byte(FNV_BASIS, stage_shadow),
                                              slot_shadow);
                    prog_open = 1'b1;
                end
                if (in_ch.has_word)
                begin
                    hash_acc = fnv_fold_word(hash_acc, in_ch.data_word);
                end
                if (in_ch.last_word)
                begin
                    expected_hashes.push_back(hash_acc);
                    prog_open = 1'b0;
                end
            end

            // A write at the same edge as a program's first transaction only
            // counts from the next program on.
            if (cfg_we)
            begin
                if (cfg_index == fph_pkg::CFG_STAGE_CODE)
                begin
                    stage_shadow = cfg_wdata[7:0];
                end
                else
                begin
                    slot_shadow = cfg_wdata;
                end
            end

            mismatch_count <= errors;
            pending_hashes <= expected_hashes.size();
        end
    end

endmodule

### dv/fnv1a64_program_hash_core_test.sv
`timescale 1ns / 1ps

// Top of the testbench. It makes the clock and reset, writes the two
// configuration registers between programs, drives programs on the input
// channel and back-pressure on the output channel, and gives the verdict.
// All hash checking lives in the checker module instantiated beside the block.
module fnv1a64_program_hash_core_test;

    // Cycles without any accepted transaction before the run is declared hung.
    // The slowest legal stretch is a long sender gap, a long output stall and
    // the folding of a first word, so this leaves a wide margin.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Extra quiet cycles after a drain before the configuration registers
    // are written.
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned RANDOM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS    = 100;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_we;
    logic           cfg_index;
    fph_pkg::word_t cfg_wdata;
    logic           gaps_on;
    logic           stalls_on;
    int unsigned    ready_hold;
    int unsigned    idle_cycles;
    int unsigned    items_sent;
    int unsigned    mismatch_count;
    int unsigned    pending_hashes;

    fph_in_if  in_ch ();
    fph_out_if out_ch ();

    fnv1a64_program_hash_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    fph_hash_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatch_count (mismatch_count),
        .pending_hashes (pending_hashes)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle lengths: half of them zero, most of the rest short, a few long.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 50);
    endfunction

    // Words lean toward the all-zero and all-one patterns now and then.
    function automatic fph_pkg::word_t pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return '0;
        end
        else if (r < 16)
        begin
            return '1;
        end
        return $urandom;
    endfunction

    // Output back-pressure. When stalls are enabled, ready alternates between
    // short runs high and stalls that are mostly short and sometimes long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            ready_hold   <= 0;
        end
        else if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1;
        end
        else if (!stalls_on)
        begin
            out_ch.ready <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_ch.ready <= 1'b0;
            ready_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 3);
        end
        else
        begin
            out_ch.ready <= 1'b1;
            ready_hold   <= $urandom_range(0, 12);
        end
    end

    // Watchdog: any accepted transaction on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one input transaction, optionally after a gap, and returns at the
    // edge where it is accepted. Valid stays high afterwards so that the next
    // transaction can follow without a bubble.
    task automatic send_item(input fph_pkg::word_t word, input logic has, input logic last);
        int unsigned gap;
        gap = gaps_on ? idle_length() : 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_word <= word;
        in_ch.has_word  <= has;
        in_ch.last_word <= last;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Holds the sender off until every expected hash has come out, then waits
    // a few more quiet cycles.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_hashes != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input fph_pkg::word_t value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Stage writes carry random upper bits, which the block must drop.
    task automatic set_identity(input fph_pkg::byte_t stage, input fph_pkg::word_t slot);
        write_reg(fph_pkg::CFG_STAGE_CODE,
                  {fph_pkg::word_t'($urandom) & 32'hFFFF_FF00} | fph_pkg::word_t'(stage));
        write_reg(fph_pkg::CFG_SLOT_BASE, slot);
    endtask

    // One random program: mostly a handful of words, sometimes only the closing
    // transaction, a few long ones. Transactions without a word are scattered in as noise.
    task automatic send_program();
        int unsigned r;
        int unsigned body;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            body = 0;
        end
        else if (r < 80)
        begin
            body = $urandom_range(1, 6);
        end
        else if (r < 95)
        begin
            body = $urandom_range(7, 20);
        end
        else
        begin
            body = $urandom_range(21, 60);
        end
        for (int unsigned k = 0; k < body; k++)
        begin
            send_item(pick_word(), $urandom_range(0, 9) != 0, 1'b0);
        end
        send_item(pick_word(), $urandom_range(0, 3) != 0, 1'b1);
    endtask

    initial
    begin
        int unsigned target;
        int unsigned r;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= fph_pkg::CFG_STAGE_CODE;
        cfg_wdata       <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_word <= '0;
        in_ch.has_word  <= 1'b0;
        in_ch.last_word <= 1'b0;
        gaps_on         <= 1'b0;
        stalls_on       <= 1'b0;
        idle_cycles     <= 0;
        items_sent       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first with the registers at their reset values.
        // Empty program: the hash of stage and slot base alone.
        send_item($urandom, 1'b0, 1'b1);
        send_item(32'h0000_0000, 1'b1, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
        // A transaction without a word in the middle of a program folds nothing.
        send_item(32'h0123_4567, 1'b1, 1'b0);
        send_item($urandom, 1'b0, 1'b0);
        send_item(32'h89AB_CDEF, 1'b1, 1'b1);
        // A program that opens and closes with transactions carrying no word.
        send_item($urandom, 1'b0, 1'b0);
        send_item(32'hDEAD_BEEF, 1'b1, 1'b0);
        send_item($urandom, 1'b0, 1'b1);
        wait_drained();

        // Both registers at their maximum.
        set_identity(8'hFF, 32'hFFFF_FFFF);
        send_item($urandom, 1'b0, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
        wait_drained();

        // Back to zero, with back-to-back empty programs.
        set_identity(8'h00, 32'h0000_0000);
        send_item($urandom, 1'b0, 1'b1);
        send_item($urandom, 1'b0, 1'b1);
        wait_drained();

        set_identity(8'h5A, 32'h8000_0001);
        send_item(32'h1234_5678, 1'b1, 1'b0);
        send_item($urandom, 1'b0, 1'b0);
        send_item($urandom, 1'b0, 1'b0);
        send_item(32'hCAFE_F00D, 1'b1, 1'b1);

        // Random part. The first phase runs without gaps or stalls; later
        // phases pick idling at random. Every phase boundary drains the
        // block completely before the registers change.
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            r = $urandom_range(0, 3);
            if (r == 0)
            begin
                set_identity(8'hFF, 32'hFFFF_FFFF);
            end
            else if (r == 1)
            begin
                set_identity(8'h00, 32'h0000_0000);
            end
            else
            begin
                set_identity(fph_pkg::byte_t'($urandom), $urandom);
            end
            gaps_on   <= (phase != 0) && ($urandom_range(0, 3) != 0);
            stalls_on <= (phase != 0) && ($urandom_range(0, 3) != 0);
            @(posedge clk);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                send_program();
            end
        end

        wait_drained();
        if (mismatch_count == 0 && pending_hashes == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
src/fph_pkg.sv
src/fph_in_if.sv
src/fph_out_if.sv
src/fnv1a64_program_hash_core.sv
dv/fph_hash_checker.sv
dv/fnv1a64_program_hash_core_test.sv
